>>> rtl/core/hbkt_pkg.sv
// Shared types, constants and helpers for the bucketed hash key table.
package hbkt_pkg;

	localparam int NUM_BUCKETS      = 99;
	localparam int SLOTS_PER_BUCKET = 4;
	localparam int NUM_SLOTS        = NUM_BUCKETS * SLOTS_PER_BUCKET;
	localparam int BKT_W            = 7;
	localparam int SLOT_W           = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam int ADDR_W           = $clog2(NUM_SLOTS);

	localparam int KEY_BYTES = 11;
	localparam int KEY_W     = 8 * KEY_BYTES;
	localparam int HI_W      = 48;
	localparam int LO_W      = 40;
	localparam int PAD_W     = 96;
	localparam int NUM_PAIRS = 6;
	localparam int PAIR_W    = $clog2(NUM_PAIRS);

	localparam int SUM_W   = 15;
	localparam int FOLD_W  = 16;
	localparam int QUOT_W  = 9;
	localparam int RECIP_SHIFT = 21;
	localparam int PROD_W  = 2 * SUM_W;

	localparam logic [7:0]        PAD_CHAR = 8'h20;
	localparam logic [FOLD_W-1:0] HASH_MUL = 16'd100;
	localparam logic [FOLD_W-1:0] HASH_MOD = 16'd20000;
	localparam logic [FOLD_W-1:0] HASH_MOD2 = 16'd40000;
	localparam logic [SUM_W-1:0]  RECIP_K =
		SUM_W'(((2 ** RECIP_SHIFT) + NUM_BUCKETS - 1) / NUM_BUCKETS);

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_REKEY  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_FOLD,
		H_MUL,
		H_RED
	} hash_state_t;

	typedef enum logic [3:0] {
		S_WIPE,
		S_IDLE,
		S_START,
		S_HASH,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_FREE,
		S_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic             done;
		logic [BKT_W-1:0] bucket;
	} hash_res_t;

	// bytes after the first zero byte are forced to zero
	function automatic logic [KEY_W-1:0] norm_key(input logic [HI_W-1:0] hi,
			input logic [LO_W-1:0] lo);
		logic [KEY_W-1:0] raw;
		logic [KEY_W-1:0] res;
		logic             ended;
		raw   = {hi, lo};
		res   = '0;
		ended = 1'b0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			if (raw[KEY_W-1-8*i -: 8] == 8'h00)
				ended = 1'b1;
			if (!ended)
				res[KEY_W-1-8*i -: 8] = raw[KEY_W-1-8*i -: 8];
		end
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [BKT_W-1:0] bkt,
			input logic [SLOT_W-1:0] idx);
		return ADDR_W'(bkt) * ADDR_W'(SLOTS_PER_BUCKET) + ADDR_W'(idx);
	endfunction

endpackage

>>> rtl/core/hbkt_ram.sv
// Generic single-port RAM with registered read data.
module hbkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/core/hbkt_hash.sv
// Iterative folding hash: one byte pair per cycle, then reciprocal mod-99 reduction.
module hbkt_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [hbkt_pkg::KEY_W-1:0] key,
	output hbkt_pkg::hash_res_t       res
);
	import hbkt_pkg::*;

	hash_state_t       state_q, state_d;
	logic [PAIR_W-1:0] pair_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] prod_q;

	logic [PAD_W-1:0]  padded;
	logic [15:0]       pairs [NUM_PAIRS];
	logic [FOLD_W-1:0] fold_sum;
	logic [SUM_W-1:0]  sum_next;
	logic [QUOT_W-1:0] quot;
	logic [FOLD_W-1:0] rem;

	always_comb begin
		padded = {key, 8'h00};
		for (int i = 0; i < PAD_W / 8; i++) begin
			if (padded[PAD_W-1-8*i -: 8] == 8'h00)
				padded[PAD_W-1-8*i -: 8] = PAD_CHAR;
		end
		for (int i = 0; i < NUM_PAIRS; i++)
			pairs[i] = padded[PAD_W-1-16*i -: 16];
	end

	always_comb begin
		fold_sum = FOLD_W'(sum_q) + FOLD_W'(pairs[pair_q][15:8]) * HASH_MUL
			+ FOLD_W'(pairs[pair_q][7:0]);
		if (fold_sum >= HASH_MOD2)
			sum_next = SUM_W'(fold_sum - HASH_MOD2);
		else if (fold_sum >= HASH_MOD)
			sum_next = SUM_W'(fold_sum - HASH_MOD);
		else
			sum_next = SUM_W'(fold_sum);
	end

	assign quot = prod_q[PROD_W-1 -: QUOT_W];
	assign rem  = FOLD_W'(sum_q) - FOLD_W'(quot) * FOLD_W'(NUM_BUCKETS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE: if (start) state_d = H_FOLD;
			H_FOLD: if (pair_q == PAIR_W'(NUM_PAIRS - 1)) state_d = H_MUL;
			H_MUL:  state_d = H_RED;
			H_RED:  state_d = H_IDLE;
			default: state_d = H_IDLE;
		endcase
	end

	always_comb begin
		res = '0;
		unique case (state_q)
			H_RED: begin
				res.done   = 1'b1;
				res.bucket = BKT_W'(rem);
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= H_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == H_IDLE && start) begin
			sum_q  <= '0;
			pair_q <= '0;
		end else if (state_q == H_FOLD) begin
			sum_q  <= sum_next;
			pair_q <= pair_q + PAIR_W'(1);
		end
		if (state_q == H_MUL)
			prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP_K);
	end

endmodule

>>> rtl/core/bucketed_hash_key_table.sv
// Top level of the bucketed hash key table: sequencer, slot valid RAM, key RAM.
// Flow: lookup, insert and delete hash the key and scan its bucket; rekey does so for the new
// key too when the old one is found, with a free step when the key moves bucket; an empty key skips both.
// Throughput: one item at a time, next transfer in the cycle its result appears; time set
// by the hash and one key RAM read per slot.
// Reset: a pass over every bucket clears the slot valid RAM with input stalled; key RAM not cleared.
module bucketed_hash_key_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [47:0] key_hi,
	input  logic [39:0] key_lo,
	input  logic [47:0] new_key_hi,
	input  logic [39:0] new_key_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [6:0]  bucket,
	output logic [1:0]  slot
);
	import hbkt_pkg::*;

	ctrl_state_t state_q, state_d;

	action_t           action_q;
	logic [KEY_W-1:0]  key_q, new_key_q;
	logic              phase_q;
	logic [BKT_W-1:0]  bk_q, cur_bkt_q;
	logic [SLOT_W-1:0] old_slot_q, scan_idx_q;
	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_idx_s1;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_slot_q;
	status_t           res_status_q;
	logic [BKT_W-1:0]  res_bkt_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [6:0]        bucket_q;
	logic [1:0]        slot_q;
	logic [BKT_W-1:0]  wipe_idx_q;
	logic [SLOTS_PER_BUCKET-1:0] old_row_q;

	logic              accept, empty_in, out_free;
	logic              hash_start, scan_rd, do_dec, out_load;
	logic              wipe, free_old;
	hash_res_t         hash_res;
	logic [KEY_W-1:0]  scan_key, ram_rdata;
	logic [SLOTS_PER_BUCKET-1:0] cur_valid;
	logic              match, free_any;
	logic [SLOT_W-1:0] free_slot;
	logic [ADDR_W-1:0] ram_addr;
	logic              vld_we;
	logic [BKT_W-1:0]  vld_addr;
	logic [SLOTS_PER_BUCKET-1:0] vld_wdata;

	status_t           dec_status;
	logic [BKT_W-1:0]  dec_bkt;
	logic [SLOT_W-1:0] dec_slot;
	logic              dec_rekey, dec_we;
	logic [BKT_W-1:0]  wr_bkt;
	logic [SLOT_W-1:0] wr_slot;
	logic [KEY_W-1:0]  wr_key;
	logic              set_en, clr_en, mv_en;

	assign accept   = in_valid && !in_stall;
	assign empty_in = (key_hi[47:40] == 8'h00)
		|| (action_t'(action) == ACT_REKEY && new_key_hi[47:40] == 8'h00);
	assign out_free = !out_valid_q || !out_stall;
	assign scan_key = phase_q ? new_key_q : key_q;
	assign match = rd_vld_s1 && cur_valid[rd_idx_s1] && (ram_rdata == scan_key);

	always_comb begin
		free_any  = 1'b0;
		free_slot = '0;
		for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
			if (!cur_valid[i]) begin
				free_any  = 1'b1;
				free_slot = SLOT_W'(i);
			end
		end
	end

	hbkt_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (scan_key),
		.res    (hash_res)
	);

	assign ram_addr = scan_rd ? slot_addr(cur_bkt_q, scan_idx_q) : slot_addr(wr_bkt, wr_slot);

	hbkt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (NUM_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (dec_we && do_dec),
		.addr  (ram_addr),
		.wdata (wr_key),
		.rdata (ram_rdata)
	);

	// one row of slot valid bits per bucket
	always_comb begin
		vld_addr  = cur_bkt_q;
		vld_wdata = cur_valid & ~(SLOTS_PER_BUCKET'(1) << hit_slot_q);
		if (wipe) begin
			vld_addr  = wipe_idx_q;
			vld_wdata = '0;
		end else if (free_old) begin
			vld_addr  = bk_q;
			vld_wdata = old_row_q & ~(SLOTS_PER_BUCKET'(1) << old_slot_q);
		end else if (set_en) begin
			vld_wdata = cur_valid | (SLOTS_PER_BUCKET'(1) << free_slot);
		end
	end

	assign vld_we = wipe || free_old || (do_dec && (set_en || clr_en));

	hbkt_ram #(
		.WIDTH (SLOTS_PER_BUCKET),
		.DEPTH (NUM_BUCKETS)
	) u_valid_ram (
		.clk   (clk),
		.we    (vld_we),
		.addr  (vld_addr),
		.wdata (vld_wdata),
		.rdata (cur_valid)
	);

	// outcome of the scan that just finished
	always_comb begin
		dec_status = ST_OK;
		dec_bkt    = cur_bkt_q;
		dec_slot   = '0;
		dec_rekey  = 1'b0;
		dec_we     = 1'b0;
		wr_bkt     = cur_bkt_q;
		wr_slot    = free_slot;
		wr_key     = key_q;
		set_en     = 1'b0;
		clr_en     = 1'b0;
		mv_en      = 1'b0;
		if (!phase_q) begin
			unique case (action_q)
				ACT_LOOKUP: begin
					dec_status = hit_q ? ST_OK : ST_NOT_FOUND;
					dec_slot   = hit_q ? hit_slot_q : '0;
				end
				ACT_INSERT: begin
					if (hit_q) begin
						dec_status = ST_DUPLICATE;
						dec_slot   = hit_slot_q;
					end else if (!free_any) begin
						dec_status = ST_FULL;
					end else begin
						dec_slot = free_slot;
						dec_we   = 1'b1;
						set_en   = 1'b1;
					end
				end
				ACT_DELETE: begin
					if (hit_q) begin
						dec_slot = hit_slot_q;
						clr_en   = 1'b1;
					end else begin
						dec_status = ST_NOT_FOUND;
					end
				end
				ACT_REKEY: begin
					if (hit_q)
						dec_rekey = 1'b1;
					else
						dec_status = ST_NOT_FOUND;
				end
				default: dec_status = ST_NOT_FOUND;
			endcase
		end else begin
			wr_key = new_key_q;
			if (hit_q) begin
				dec_status = ST_DUPLICATE;
				dec_slot   = hit_slot_q;
			end else if (cur_bkt_q == bk_q) begin
				dec_slot = old_slot_q;
				dec_we   = 1'b1;
				wr_slot  = old_slot_q;
			end else if (!free_any) begin
				dec_status = ST_FULL;
			end else begin
				dec_slot = free_slot;
				dec_we   = 1'b1;
				set_en   = 1'b1;
				mv_en    = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_WIPE:     if (wipe_idx_q == BKT_W'(NUM_BUCKETS - 1)) state_d = S_IDLE;
			S_IDLE:     if (accept) state_d = empty_in ? S_DONE : S_START;
			S_START:    state_d = S_HASH;
			S_HASH:     if (hash_res.done) state_d = S_SCAN;
			S_SCAN:     if (scan_idx_q == SLOT_W'(SLOTS_PER_BUCKET - 1)) state_d = S_SCAN_END;
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				if (dec_rekey)
					state_d = S_START;
				else if (mv_en)
					state_d = S_FREE;
				else
					state_d = S_DONE;
			end
			S_FREE:     state_d = S_DONE;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		hash_start = 1'b0;
		scan_rd    = 1'b0;
		do_dec     = 1'b0;
		out_load   = 1'b0;
		wipe       = 1'b0;
		free_old   = 1'b0;
		unique case (state_q)
			S_WIPE:   wipe = 1'b1;
			S_IDLE:   in_stall = 1'b0;
			S_START:  hash_start = 1'b1;
			S_SCAN:   scan_rd = 1'b1;
			S_DECIDE: do_dec = 1'b1;
			S_FREE:   free_old = 1'b1;
			S_DONE:   out_load = out_free;
			default:  in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_WIPE;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			wipe_idx_q  <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= scan_rd;
			if (wipe)
				wipe_idx_q <= wipe_idx_q + BKT_W'(1);
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q;
		if (accept) begin
			action_q     <= action_t'(action);
			key_q        <= norm_key(key_hi, key_lo);
			new_key_q    <= norm_key(new_key_hi, new_key_lo);
			phase_q      <= 1'b0;
			res_status_q <= ST_EMPTY;
			res_bkt_q    <= '0;
			res_slot_q   <= '0;
		end
		if (state_q == S_HASH && hash_res.done) begin
			cur_bkt_q  <= hash_res.bucket;
			if (!phase_q)
				bk_q <= hash_res.bucket;
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
		end
		if (scan_rd)
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
		if (match && !hit_q) begin
			hit_q      <= 1'b1;
			hit_slot_q <= rd_idx_s1;
		end
		if (do_dec) begin
			res_status_q <= dec_status;
			res_bkt_q    <= dec_bkt;
			res_slot_q   <= dec_slot;
			if (dec_rekey) begin
				phase_q    <= 1'b1;
				old_slot_q <= hit_slot_q;
				old_row_q  <= cur_valid;
			end
		end
		if (out_load) begin
			status_q <= res_status_q;
			bucket_q <= res_bkt_q;
			slot_q   <= 2'(res_slot_q);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bucket    = bucket_q;
	assign slot      = slot_q;

	a_no_set_clr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_dec && set_en && clr_en))
		else $error("slot set and freed in one decision");

	a_free_other_bucket: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FREE |-> bk_q != cur_bkt_q)
		else $error("old slot freed in the target bucket");

	a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_res.done |-> state_q == S_HASH)
		else $error("hash result outside hash wait");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("transfer taken without leaving idle");

endmodule
